[rtl/core/clns_pkg.sv]
// shared types, codes and constants for the character lcd nibble sequencer
// no dependencies; every module of the block imports this package
package clns_pkg;

	// request actions
	localparam logic [2:0] ACT_INIT   = 3'd0;
	localparam logic [2:0] ACT_CMD    = 3'd1;
	localparam logic [2:0] ACT_CHAR   = 3'd2;
	localparam logic [2:0] ACT_CURSOR = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	// configuration register indexes
	localparam logic CFG_ENABLE_HIGH = 1'b0;
	localparam logic CFG_SETTLE      = 1'b1;

	localparam int CFG_DATA_W = 10;

	// reset values of the timing registers
	localparam logic [7:0] ENABLE_HIGH_RST = 8'd3;
	localparam logic [9:0] SETTLE_RST      = 10'd50;

	// fixed holds in microseconds
	localparam logic [15:0] HOLD_POWER_UP = 16'd40000;
	localparam logic [15:0] HOLD_LONG     = 16'd5000;
	localparam logic [15:0] HOLD_MID      = 16'd100;
	localparam logic [15:0] HOLD_CURSOR   = 16'd1000;

	// display command bytes
	localparam logic [7:0] CMD_CLEAR = 8'h01;

	// init sequence landmarks (step numbers within an init job)
	localparam logic [4:0] INIT_FIRST_BYTE_STEP = 5'd9;
	localparam logic [4:0] INIT_LAST_STEP       = 5'd25;

	// default depth of the job queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] byte_value;
		logic       row;
		logic [5:0] column;
	} in_item_t;

	typedef struct packed {
		logic        reg_select;
		logic        read_write;
		logic        enable_pin;
		logic [3:0]  data_nibble;
		logic        backlight_on;
		logic [15:0] hold_us;
		logic        last_step;
	} out_item_t;

	typedef struct packed {
		logic [7:0] enable_high_us;
		logic [9:0] settle_us;
	} timing_t;

	typedef enum logic [1:0] {
		JOB_INIT,
		JOB_BYTE,
		JOB_CHAR,
		JOB_CURSOR
	} job_kind_t;

	// one classified request, as queued for the back end
	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] byte_val;
		logic       long_wait;
	} job_t;

	// command bytes sent during init, after the nibble-mode wake-up
	function automatic logic [7:0] init_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = 8'h28;
			2'd1:    b = 8'h0C;
			2'd2:    b = 8'h06;
			default: b = CMD_CLEAR;
		endcase
		return b;
	endfunction

endpackage

[rtl/core/clns_front.sv]
// front end: accepts requests, drops unused actions, classifies into jobs
// depends on clns_pkg
module clns_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  clns_pkg::in_item_t in_item,
	input  logic              queue_full,
	output logic              push,
	output clns_pkg::job_t    push_job
);
	import clns_pkg::*;

	logic  valid_s1;
	job_t  job_s1;
	job_t  job_d;
	logic  known_d;
	logic  accept;

	// classify the incoming request
	always_comb begin
		known_d        = 1'b1;
		job_d.kind     = JOB_BYTE;
		job_d.byte_val = in_item.byte_value;
		job_d.long_wait = 1'b0;
		unique case (in_item.action)
			ACT_INIT: begin
				job_d.kind = JOB_INIT;
			end
			ACT_CMD: begin
				job_d.kind = JOB_BYTE;
			end
			ACT_CHAR: begin
				job_d.kind = JOB_CHAR;
			end
			ACT_CURSOR: begin
				job_d.kind      = JOB_CURSOR;
				job_d.byte_val  = {1'b1, in_item.row, in_item.column};
				job_d.long_wait = 1'b1;
			end
			ACT_CLEAR: begin
				job_d.kind      = JOB_BYTE;
				job_d.byte_val  = CMD_CLEAR;
				job_d.long_wait = 1'b1;
			end
			default: begin
				known_d = 1'b0;
			end
		endcase
	end

	// handshake: stage empties into the queue, refills in the same cycle
	assign push     = valid_s1 && !queue_full;
	assign in_stall = valid_s1 && queue_full;
	assign accept   = in_valid && !in_stall;
	assign push_job = job_s1;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= known_d;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job_d;
		end
	end

endmodule

[rtl/core/clns_queue.sv]
// small job queue between the front and back ends
// depends on clns_pkg
module clns_queue #(
	parameter int DEPTH = clns_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  clns_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output clns_pkg::job_t head_job
);
	import clns_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_job = mem[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count above depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("request pushed into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("job popped from empty queue");
`endif

endmodule

[rtl/core/clns_back.sv]
// back end: steps through one job at a time, one pin state per cycle while out is not stalled
// depends on clns_pkg; holds the pin state and the output register
module clns_back (
	input  logic               clk,
	input  logic               arst_n,
	input  clns_pkg::timing_t  timing,
	input  logic               queue_empty,
	input  clns_pkg::job_t     head_job,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output clns_pkg::out_item_t out_item
);
	import clns_pkg::*;

	job_t       job_q;
	logic       busy_q;
	logic [4:0] step_q;
	logic [3:0] pin_nibble_q;
	logic       pin_rs_q;
	logic       pin_bl_q;
	out_item_t  out_q;
	logic       out_valid_q;

	out_item_t  step_item;
	logic       advance;
	logic       step_done;

	// pin state for the current step of the current job
	always_comb begin
		logic        byte_mode;
		logic [7:0]  b;
		logic [1:0]  k;
		logic [15:0] extra;
		logic [15:0] pulse_extra;
		logic [4:0]  step_m1;
		logic [4:0]  step_m9;

		step_m1     = step_q - 5'd1;
		step_m9     = step_q - INIT_FIRST_BYTE_STEP;
		byte_mode   = 1'b0;
		b           = job_q.byte_val;
		k           = step_q[1:0];
		extra       = job_q.long_wait ? HOLD_LONG : 16'd0;
		pulse_extra = 16'd0;

		step_item.reg_select   = pin_rs_q;
		step_item.read_write   = 1'b0;
		step_item.enable_pin   = 1'b0;
		step_item.data_nibble  = pin_nibble_q;
		step_item.backlight_on = pin_bl_q;
		step_item.hold_us      = 16'd0;
		step_item.last_step    = 1'b0;

		unique case (job_q.kind)
			JOB_BYTE: begin
				byte_mode           = 1'b1;
				step_item.last_step = (step_q == 5'd3);
			end
			JOB_CHAR: begin
				if (step_q < 5'd4) begin
					byte_mode            = 1'b1;
					step_item.reg_select = 1'b1;
				end else begin
					// rs falls back to command, nothing else moves
					step_item.reg_select = 1'b0;
				end
				extra               = 16'd0;
				step_item.last_step = (step_q == 5'd4);
			end
			JOB_CURSOR: begin
				if (step_q == 5'd0) begin
					step_item.hold_us = HOLD_CURSOR;
				end else begin
					byte_mode = 1'b1;
					k         = step_m1[1:0];
				end
				step_item.last_step = (step_q == 5'd4);
			end
			JOB_INIT: begin
				if (step_q == 5'd0) begin
					// power-up wait with everything low
					step_item.backlight_on = 1'b0;
					step_item.data_nibble  = 4'd0;
					step_item.hold_us      = HOLD_POWER_UP;
				end else if (step_q < INIT_FIRST_BYTE_STEP) begin
					// wake-up pulses: three of 0x3, one of 0x2
					step_item.reg_select  = 1'b0;
					step_item.data_nibble = (step_q < 5'd7) ? 4'd3 : 4'd2;
					step_item.enable_pin  = step_q[0];
					if (step_q == 5'd2) begin
						pulse_extra = HOLD_LONG;
					end else if (step_q == 5'd4) begin
						pulse_extra = HOLD_MID;
					end
					step_item.hold_us = step_q[0] ? {8'd0, timing.enable_high_us}
						: {6'd0, timing.settle_us} + pulse_extra;
				end else if (step_q < INIT_LAST_STEP) begin
					// function set, display on, entry mode, clear
					byte_mode            = 1'b1;
					step_item.reg_select = 1'b0;
					b                    = init_byte(step_m9[3:2]);
					k                    = step_m9[1:0];
					extra                = (step_m9[3:2] == 2'd3) ? HOLD_LONG : 16'd0;
				end else begin
					step_item.reg_select   = 1'b0;
					step_item.backlight_on = 1'b1;
					step_item.last_step    = 1'b1;
				end
			end
			default: begin
				step_item.last_step = 1'b1;
			end
		endcase

		// one nibble of a byte, high nibble first, enable high then low
		if (byte_mode) begin
			step_item.data_nibble = k[1] ? b[3:0] : b[7:4];
			step_item.enable_pin  = !k[0];
			step_item.hold_us     = !k[0] ? {8'd0, timing.enable_high_us}
				: {6'd0, timing.settle_us} + ((k == 2'd3) ? extra : 16'd0);
		end
	end

	assign advance   = !out_valid_q || !out_stall;
	assign step_done = busy_q && advance && step_item.last_step;
	assign pop       = !queue_empty && (!busy_q || step_done);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// job control, pin state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
			pin_nibble_q <= '0;
			pin_rs_q     <= 1'b0;
			pin_bl_q     <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (busy_q && advance) begin
				pin_nibble_q <= step_item.data_nibble;
				pin_rs_q     <= step_item.reg_select;
				pin_bl_q     <= step_item.backlight_on;
			end
			if (pop) begin
				step_q <= '0;
			end else if (busy_q && advance) begin
				step_q <= step_q + 5'd1;
			end
			if (pop) begin
				busy_q <= 1'b1;
			end else if (step_done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
		if (busy_q && advance) begin
			out_q <= step_item;
		end
	end

`ifndef ASSERT_OFF
	a_init_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && job_q.kind == JOB_INIT |-> step_q <= INIT_LAST_STEP)
		else $error("init job ran past its last step");
	a_short_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && job_q.kind != JOB_INIT |-> step_q <= 5'd4)
		else $error("short job ran past its last step");
	a_step_emitted: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && advance |=> out_valid_q)
		else $error("step produced without a valid output");
	a_enable_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_stall && out_q.enable_pin |=> out_valid_q && !out_q.enable_pin
			&& out_q.data_nibble == $past(out_q.data_nibble))
		else $error("enable high step not followed by a matching low step");
`endif

endmodule

[rtl/core/char_lcd_nibble_sequencer.sv]
// top level of the character lcd nibble sequencer: timing registers and wiring
// depends on clns_pkg, clns_front, clns_queue, clns_back
//
//  channel | signals                          | direction | moves
//  in      | in_valid, in_stall, in_item      | into block| one request
//  out     | out_valid, out_stall, out_item   | out       | one pin state step
//  cfg     | cfg_we, cfg_index, cfg_data      | into block| one timing register
//
// one pin state step leaves per cycle while out is not stalled; the back end step counter
// sets how many steps a command byte, clear, character, cursor move or init takes.
// a request with an unused action is taken and gives nothing.
// reset clears the pin state, the queue and all valids; timing registers
// return to 3 us enable high and 50 us settle. requests keep being taken
// while out is stalled until the front stage and the job queue are full.
module char_lcd_nibble_sequencer #(
	parameter int QUEUE_DEPTH = clns_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  clns_pkg::in_item_t                in_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output clns_pkg::out_item_t               out_item,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [clns_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import clns_pkg::*;

	timing_t timing_q;
	logic    queue_full;
	logic    queue_empty;
	logic    push;
	logic    pop;
	job_t    push_job;
	job_t    head_job;

	// timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.enable_high_us <= ENABLE_HIGH_RST;
			timing_q.settle_us      <= SETTLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE_HIGH: timing_q.enable_high_us <= cfg_data[7:0];
				CFG_SETTLE:      timing_q.settle_us      <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	clns_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	clns_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (queue_full),
		.pop      (pop),
		.empty    (queue_empty),
		.head_job (head_job)
	);

	clns_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.timing      (timing_q),
		.queue_empty (queue_empty),
		.head_job    (head_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item)
	);

endmodule
